[rtl/lcfe_pkg.sv]
`default_nettype none
package lcfe_pkg;

	localparam int IDX_FIELD_W = 6;
	localparam int COLOR_W     = 32;
	localparam int DUR_W       = 15;
	localparam int CH_W        = 8;
	localparam int LANES       = COLOR_W / CH_W;
	localparam int NUM_W       = 24;
	localparam int DEN_W       = DUR_W + 1;
	localparam int QUO_W       = CH_W;
	localparam int PROD_W      = NUM_W - 1;
	localparam int CFG_IDX_W   = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_DURATION = 4'd1;

	localparam logic KIND_CHANGE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	typedef struct packed {
		logic                   kind;
		logic [IDX_FIELD_W-1:0] led_index;
		logic [COLOR_W-1:0]     color;
		logic [DUR_W-1:0]       duration;
	} lcfe_in_t;

	typedef struct packed {
		logic [IDX_FIELD_W-1:0] pixel_index;
		logic [COLOR_W-1:0]     pixel_value;
		logic                   frame_end;
	} lcfe_out_t;

	typedef struct packed {
		logic [COLOR_W-1:0] start;
		logic [COLOR_W-1:0] target;
		logic [DUR_W-1:0]   total;
		logic [DUR_W-1:0]   elapsed;
	} fade_rec_t;

	typedef struct packed {
		logic accept;
		logic sel_chg;
		logic rd;
		logic mul;
		logic div_start;
		logic wr_tick;
		logic wr_chg;
	} lcfe_cmd_t;

	typedef struct packed {
		logic chg_ok;
		logic need_blend;
		logic div_done;
	} lcfe_sts_t;

endpackage
`default_nettype wire

[rtl/led_color_fade_engine.sv]
// tick: LED_COUNT transfers out, one led at a time; a led that only holds or starts a fade is
// read, evaluated, written and sent, one that blends also multiplies and waits for the 8-step
// restoring divider per byte before its write; a stalled output holds the frame
// change: check index, read, write, no output (out-of-range: nothing); next item taken in idle
// reset clears all pixel colours to zero, all fades to idle and both config registers
`default_nettype none
module led_color_fade_engine #(
	parameter int LED_COUNT = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire lcfe_pkg::lcfe_in_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output lcfe_pkg::lcfe_out_t                 out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [lcfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lcfe_pkg::COLOR_W-1:0]   cfg_data
);

	localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	logic [lcfe_pkg::COLOR_W-1:0] bg_color_q;
	logic [lcfe_pkg::DUR_W-1:0]   bg_dur_q;
	lcfe_pkg::lcfe_cmd_t          cmd;
	lcfe_pkg::lcfe_sts_t          sts;
	logic [IDX_W-1:0]             idx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_color_q <= '0;
			bg_dur_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lcfe_pkg::CFG_BG_COLOR:    bg_color_q <= cfg_data;
				lcfe_pkg::CFG_BG_DURATION: bg_dur_q   <= cfg_data[lcfe_pkg::DUR_W-1:0];
				default: ;
			endcase
		end
	end

	lcfe_ctrl #(
		.LED_COUNT (LED_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_kind   (in_data.kind),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.idx       (idx)
	);

	lcfe_datapath #(
		.LED_COUNT (LED_COUNT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.idx      (idx),
		.in_data  (in_data),
		.bg_color (bg_color_q),
		.bg_dur   (bg_dur_q),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

[rtl/lcfe_div.sv]
`default_nettype none
module lcfe_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [lcfe_pkg::NUM_W-1:0] num,
	input  wire logic [lcfe_pkg::DEN_W-1:0] den,
	output logic                            done,
	output logic [lcfe_pkg::QUO_W-1:0]      quo
);

	localparam int CNT_W = $clog2(lcfe_pkg::QUO_W);
	localparam int PAD_W = lcfe_pkg::NUM_W - lcfe_pkg::DEN_W - (lcfe_pkg::QUO_W - 1);

	logic [lcfe_pkg::NUM_W-1:0] rem_q;
	logic [lcfe_pkg::NUM_W-1:0] dsh_q;
	logic [lcfe_pkg::QUO_W-1:0] quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       ge;

	// quotient is known to fit in QUO_W bits, so only that many restoring steps
	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(lcfe_pkg::QUO_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {{PAD_W{1'b0}}, den, {(lcfe_pkg::QUO_W - 1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[lcfe_pkg::QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

[rtl/lcfe_ctrl.sv]
`default_nettype none
module lcfe_ctrl #(
	parameter int LED_COUNT = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_kind,
	output logic                       in_stall,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	input  wire lcfe_pkg::lcfe_sts_t   sts,
	output lcfe_pkg::lcfe_cmd_t        cmd,
	output logic [((LED_COUNT > 1) ? $clog2(LED_COUNT) : 1)-1:0] idx
);

	localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CRD  = 4'd1;
	localparam logic [3:0] S_CWR  = 4'd2;
	localparam logic [3:0] S_TRD  = 4'd3;
	localparam logic [3:0] S_EVAL = 4'd4;
	localparam logic [3:0] S_DIVS = 4'd5;
	localparam logic [3:0] S_DIVW = 4'd6;
	localparam logic [3:0] S_WR   = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [3:0]       state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             last;

	assign last = idx_q == IDX_W'(LED_COUNT - 1);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		idx_d   = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					idx_d      = '0;
					state_d    = (in_kind == lcfe_pkg::KIND_TICK) ? S_TRD : S_CRD;
				end
			end
			S_CRD: begin
				cmd.sel_chg = 1'b1;
				if (sts.chg_ok) begin
					cmd.rd  = 1'b1;
					state_d = S_CWR;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_CWR: begin
				cmd.sel_chg = 1'b1;
				cmd.wr_chg  = 1'b1;
				state_d     = S_IDLE;
			end
			S_TRD: begin
				cmd.rd  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (sts.need_blend) begin
					cmd.mul = 1'b1;
					state_d = S_DIVS;
				end else begin
					state_d = S_WR;
				end
			end
			S_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (sts.div_done) begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				cmd.wr_tick = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					if (last) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_TRD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign idx       = idx_q;

endmodule
`default_nettype wire

[rtl/lcfe_datapath.sv]
`default_nettype none
module lcfe_datapath #(
	parameter int LED_COUNT = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lcfe_pkg::lcfe_cmd_t          cmd,
	input  wire logic [((LED_COUNT > 1) ? $clog2(LED_COUNT) : 1)-1:0] idx,
	input  wire lcfe_pkg::lcfe_in_t           in_data,
	input  wire logic [lcfe_pkg::COLOR_W-1:0] bg_color,
	input  wire logic [lcfe_pkg::DUR_W-1:0]   bg_dur,
	output lcfe_pkg::lcfe_sts_t               sts,
	output lcfe_pkg::lcfe_out_t               out_data
);

	localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	lcfe_pkg::lcfe_in_t  in_q;
	lcfe_pkg::lcfe_out_t out_q;

	logic [lcfe_pkg::COLOR_W-1:0] pix_mem [LED_COUNT];
	lcfe_pkg::fade_rec_t          rec_mem [LED_COUNT];
	logic [LED_COUNT-1:0]         pix_vld_q;
	logic [LED_COUNT-1:0]         act_q;

	logic [lcfe_pkg::COLOR_W-1:0] pix_rd_q;
	lcfe_pkg::fade_rec_t          rec_rd_q;
	logic                         vld_rd_q;
	logic                         act_rd_q;

	logic [IDX_W-1:0]             chg_addr;
	logic [IDX_W-1:0]             addr;
	logic [lcfe_pkg::COLOR_W-1:0] pix_cur;
	logic [lcfe_pkg::DUR_W-1:0]   e_nxt;
	logic [lcfe_pkg::DUR_W-1:0]   t_m_e;
	logic                         fade_end;
	logic [lcfe_pkg::COLOR_W-1:0] quo_all;
	logic [lcfe_pkg::COLOR_W-1:0] pix_new;
	logic                         pix_we;
	logic                         rec_we;
	lcfe_pkg::fade_rec_t          rec_wd;
	logic                         act_we;
	logic                         act_wd;

	logic [lcfe_pkg::NUM_W-1:0]   num_q    [lcfe_pkg::LANES];
	logic [lcfe_pkg::QUO_W-1:0]   quo      [lcfe_pkg::LANES];
	logic [lcfe_pkg::LANES-1:0]   div_done;
	logic [lcfe_pkg::DEN_W-1:0]   den;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_q <= in_data;
		end
	end

	assign chg_addr = in_q.led_index[IDX_W-1:0];
	assign addr     = cmd.sel_chg ? chg_addr : idx;

	// record memories: registered read, one write port
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			pix_rd_q <= pix_mem[addr];
			rec_rd_q <= rec_mem[addr];
		end
		if (pix_we) begin
			pix_mem[addr] <= pix_new;
		end
		if (rec_we) begin
			rec_mem[addr] <= rec_wd;
		end
	end

	// per-led valid and fade-active flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_vld_q <= '0;
			act_q     <= '0;
			vld_rd_q  <= 1'b0;
			act_rd_q  <= 1'b0;
		end else begin
			if (cmd.rd) begin
				vld_rd_q <= pix_vld_q[addr];
				act_rd_q <= act_q[addr];
			end
			if (pix_we) begin
				pix_vld_q[addr] <= 1'b1;
			end
			if (act_we) begin
				act_q[addr] <= act_wd;
			end
		end
	end

	assign pix_cur  = vld_rd_q ? pix_rd_q : '0;
	assign e_nxt    = rec_rd_q.elapsed + 1'b1;
	assign t_m_e    = rec_rd_q.total - e_nxt;
	assign fade_end = e_nxt >= rec_rd_q.total;
	assign den      = {rec_rd_q.total, 1'b0};

	// num = 2*(a*(t-e) + b*e) + t, quotient by 2t gives the rounded blend
	for (genvar c = 0; c < lcfe_pkg::LANES; c++) begin : g_lane
		logic [lcfe_pkg::PROD_W-1:0] prod_a;
		logic [lcfe_pkg::PROD_W-1:0] prod_b;

		assign prod_a = lcfe_pkg::PROD_W'(rec_rd_q.start[c*lcfe_pkg::CH_W +: lcfe_pkg::CH_W])
			* lcfe_pkg::PROD_W'(t_m_e);
		assign prod_b = lcfe_pkg::PROD_W'(rec_rd_q.target[c*lcfe_pkg::CH_W +: lcfe_pkg::CH_W])
			* lcfe_pkg::PROD_W'(e_nxt);

		always_ff @(posedge clk) begin
			if (cmd.mul) begin
				num_q[c] <= {prod_a + prod_b, 1'b0} + lcfe_pkg::NUM_W'(rec_rd_q.total);
			end
		end

		lcfe_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (cmd.div_start),
			.num    (num_q[c]),
			.den    (den),
			.done   (div_done[c]),
			.quo    (quo[c])
		);

		assign quo_all[c*lcfe_pkg::CH_W +: lcfe_pkg::CH_W] = quo[c];
	end

	always_comb begin
		pix_new = pix_cur;
		pix_we  = 1'b0;
		rec_we  = 1'b0;
		rec_wd  = rec_rd_q;
		act_we  = 1'b0;
		act_wd  = 1'b0;
		if (cmd.wr_chg) begin
			rec_we         = 1'b1;
			rec_wd.start   = pix_cur;
			rec_wd.target  = in_q.color;
			rec_wd.total   = in_q.duration;
			rec_wd.elapsed = '0;
			act_we         = 1'b1;
			act_wd         = 1'b1;
		end else if (cmd.wr_tick) begin
			if (act_rd_q) begin
				rec_we         = 1'b1;
				rec_wd.elapsed = e_nxt;
				act_we         = 1'b1;
				act_wd         = !fade_end;
				pix_we         = 1'b1;
				pix_new        = fade_end ? rec_rd_q.target : quo_all;
			end else if (pix_cur != bg_color) begin
				// idle led drifts back to the background colour
				rec_we         = 1'b1;
				rec_wd.start   = pix_cur;
				rec_wd.target  = bg_color;
				rec_wd.total   = bg_dur;
				rec_wd.elapsed = '0;
				act_we         = 1'b1;
				act_wd         = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_tick) begin
			out_q.pixel_index <= lcfe_pkg::IDX_FIELD_W'(idx);
			out_q.pixel_value <= pix_new;
			out_q.frame_end   <= idx == IDX_W'(LED_COUNT - 1);
		end
	end

	assign sts.chg_ok     = {1'b0, in_q.led_index} < (lcfe_pkg::IDX_FIELD_W + 1)'(LED_COUNT);
	assign sts.need_blend = act_rd_q && !fade_end;
	assign sts.div_done   = &div_done;
	assign out_data       = out_q;

endmodule
`default_nettype wire

[rtl/lcfe_checker.sv]
`default_nettype none
module lcfe_checker #(
	parameter int LED_COUNT = 32
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire lcfe_pkg::lcfe_out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a frame result is pending");

	a_end_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |->
			out_data.pixel_index == lcfe_pkg::IDX_FIELD_W'(LED_COUNT - 1))
		else $error("frame end on wrong led");

	a_frame_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.frame_end |=> !out_valid)
		else $error("result after frame end");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken straight after a transfer");

endmodule

bind led_color_fade_engine lcfe_checker #(
	.LED_COUNT (LED_COUNT)
) u_lcfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire

[tb/lcfe_frame_checker.sv]
`timescale 1ns / 1ps
module lcfe_frame_checker #(
	parameter int LED_COUNT = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  lcfe_pkg::lcfe_in_t             in_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  lcfe_pkg::lcfe_out_t            out_data,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [lcfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lcfe_pkg::COLOR_W-1:0]   cfg_data,
	output int                             mismatch_count,
	output int                             pending_results
);

	logic [lcfe_pkg::COLOR_W-1:0] bg_color;
	logic [lcfe_pkg::DUR_W-1:0]   bg_ticks;
	logic [lcfe_pkg::COLOR_W-1:0] pixel [LED_COUNT];
	logic                         fading [LED_COUNT];
	lcfe_pkg::fade_rec_t          fade [LED_COUNT];
	lcfe_pkg::lcfe_out_t          expected_pixels_q [$];
	int                           errors = 0;

	// per byte: floor(a + (b-a)*step/span + 1/2), done exactly in integers
	function automatic logic [lcfe_pkg::COLOR_W-1:0] mix_rgbw(
			input logic [lcfe_pkg::COLOR_W-1:0] from_c,
			input logic [lcfe_pkg::COLOR_W-1:0] to_c, input logic [lcfe_pkg::DUR_W-1:0] step,
			input logic [lcfe_pkg::DUR_W-1:0] span);
		logic [lcfe_pkg::COLOR_W-1:0] mixed;
		longint a, b, t, num;
		mixed = '0;
		t = span;
		for (int lane = 0; lane < lcfe_pkg::LANES; lane++) begin
			a = from_c[lane*lcfe_pkg::CH_W +: lcfe_pkg::CH_W];
			b = to_c[lane*lcfe_pkg::CH_W +: lcfe_pkg::CH_W];
			num = 2 * a * t + 2 * (b - a) * longint'(step) + t;
			mixed[lane*lcfe_pkg::CH_W +: lcfe_pkg::CH_W] = lcfe_pkg::CH_W'(num / (2 * t));
		end
		return mixed;
	endfunction

	task automatic launch_fade(input int led, input logic [lcfe_pkg::COLOR_W-1:0] goal,
			input logic [lcfe_pkg::DUR_W-1:0] ticks);
		fade[led].start   = pixel[led];
		fade[led].target  = goal;
		fade[led].total   = ticks;
		fade[led].elapsed = '0;
		fading[led]       = 1'b1;
	endtask

	task automatic predict_frame();
		lcfe_pkg::lcfe_out_t        px;
		logic [lcfe_pkg::DUR_W-1:0] step;
		for (int led = 0; led < LED_COUNT; led++) begin
			if (fading[led]) begin
				step = fade[led].elapsed + 1'b1;
				fade[led].elapsed = step;
				if (step >= fade[led].total) begin
					pixel[led]  = fade[led].target;
					fading[led] = 1'b0;
				end else begin
					pixel[led] = mix_rgbw(fade[led].start, fade[led].target, step,
						fade[led].total);
				end
			end else if (pixel[led] != bg_color) begin
				// idle led drifts back to the background, colour held this tick
				launch_fade(led, bg_color, bg_ticks);
			end
		end
		for (int led = 0; led < LED_COUNT; led++) begin
			px.pixel_index = lcfe_pkg::IDX_FIELD_W'(led);
			px.pixel_value = pixel[led];
			px.frame_end   = (led == LED_COUNT - 1);
			expected_pixels_q.push_back(px);
		end
	endtask

	task automatic note_mismatch(input string what, input lcfe_pkg::lcfe_out_t want,
			input lcfe_pkg::lcfe_out_t got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s: expected led %0d colour %08h end %0b, got led %0d colour %08h end %0b",
				$realtime, what, want.pixel_index, want.pixel_value, want.frame_end,
				got.pixel_index, got.pixel_value, got.frame_end);
	endtask

	always @(posedge clk or negedge arst_n) begin
		lcfe_pkg::lcfe_out_t want;
		if (!arst_n) begin
			bg_color = '0;
			bg_ticks = '0;
			for (int led = 0; led < LED_COUNT; led++) begin
				pixel[led]  = '0;
				fading[led] = 1'b0;
				fade[led]   = '0;
			end
			expected_pixels_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == lcfe_pkg::CFG_BG_COLOR)
					bg_color = cfg_data;
				else if (cfg_index == lcfe_pkg::CFG_BG_DURATION)
					bg_ticks = cfg_data[lcfe_pkg::DUR_W-1:0];
			end
			if (out_valid && !out_stall) begin
				if (expected_pixels_q.size() == 0) begin
					note_mismatch("unexpected pixel transfer", '0, out_data);
				end else begin
					want = expected_pixels_q.pop_front();
					if (out_data.pixel_index !== want.pixel_index ||
							out_data.pixel_value !== want.pixel_value ||
							out_data.frame_end !== want.frame_end)
						note_mismatch("pixel mismatch", want, out_data);
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.kind == lcfe_pkg::KIND_TICK)
					predict_frame();
				else if (in_data.led_index < LED_COUNT)
					launch_fade(in_data.led_index, in_data.color, in_data.duration);
			end
		end
		mismatch_count  <= errors;
		pending_results <= expected_pixels_q.size();
	end

endmodule

[tb/tb_led_color_fade_engine.sv]
`timescale 1ns / 1ps
module tb_led_color_fade_engine;

	localparam int LEDS = 32;
	localparam logic [lcfe_pkg::CFG_IDX_W-1:0] CFG_SPARE = 4'd15;
	localparam int CHANGE_SETTLE = 20;
	localparam int PHASE_ITEMS = 60;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	lcfe_pkg::lcfe_in_t             in_data = '0;
	logic                           out_stall = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic [lcfe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lcfe_pkg::COLOR_W-1:0]   cfg_data = '0;
	logic                           in_stall;
	logic                           out_valid;
	logic                           cfg_ready;
	lcfe_pkg::lcfe_out_t            out_data;
	int                             mismatch_count;
	int                             pending_results;
	int                             items_sent = 0;
	int                             pixels_taken = 0;
	logic [lcfe_pkg::COLOR_W-1:0]   bg_now = '0;

	led_color_fade_engine #(
		.LED_COUNT(LEDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	lcfe_frame_checker #(
		.LED_COUNT(LEDS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.pending_results(pending_results)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic offer_led_cmd(input logic kind, input int led,
			input logic [lcfe_pkg::COLOR_W-1:0] color, input int ticks);
		lcfe_pkg::lcfe_in_t item;
		int                 gap;
		item.kind      = kind;
		item.led_index = lcfe_pkg::IDX_FIELD_W'(led);
		item.color     = color;
		item.duration  = lcfe_pkg::DUR_W'(ticks);
		// every third stretch of forty transfers goes back to back
		gap = ((items_sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// a change has no result, so allow for its own latency after the last frame
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (CHANGE_SETTLE) @(posedge clk);
	endtask

	task automatic program_background(input logic [lcfe_pkg::COLOR_W-1:0] color,
			input logic [lcfe_pkg::COLOR_W-1:0] ticks_word, input logic poke_spare);
		cfg_index <= lcfe_pkg::CFG_BG_COLOR;
		cfg_data  <= color;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= lcfe_pkg::CFG_BG_DURATION;
		cfg_data  <= ticks_word;
		do @(posedge clk); while (!cfg_ready);
		if (poke_spare) begin
			cfg_index <= CFG_SPARE;
			cfg_data  <= $urandom();
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		bg_now = color;
	endtask

	task automatic random_phase(input int quota);
		int                           counted;
		int                           pick;
		int                           led;
		int                           ticks;
		logic [lcfe_pkg::COLOR_W-1:0] color;
		counted = 0;
		while (counted < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				offer_led_cmd(lcfe_pkg::KIND_TICK, $urandom_range(0, 63), $urandom(),
					$urandom_range(0, 32767));
				counted++;
			end else begin
				led = (pick < 42) ? $urandom_range(LEDS, 63) : $urandom_range(0, LEDS - 1);
				pick = $urandom_range(0, 9);
				// mostly short fades so that they run to their end
				ticks = (pick < 7) ? $urandom_range(0, 6) :
					(pick < 9) ? $urandom_range(7, 40) : $urandom_range(0, 32767);
				color = ($urandom_range(0, 4) == 0) ? bg_now : $urandom();
				offer_led_cmd(lcfe_pkg::KIND_CHANGE, led, color, ticks);
				if (led < LEDS)
					counted++;
			end
		end
	endtask

	initial begin
		int hold;
		wait (arst_n);
		forever begin
			if (pixels_taken == 100 || pixels_taken == 1500)
				hold = 400;
			else if ((pixels_taken / 128) % 3 == 1)
				hold = 0;
			else
				hold = $urandom_range(0, 5);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			pixels_taken++;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		offer_led_cmd(lcfe_pkg::KIND_CHANGE, 0, 32'hFFFF_FFFF, 0);
		offer_led_cmd(lcfe_pkg::KIND_CHANGE, LEDS - 1, 32'hFF00_FF00, 32767);
		offer_led_cmd(lcfe_pkg::KIND_CHANGE, 63, 32'hFFFF_FFFF, 5);
		offer_led_cmd(lcfe_pkg::KIND_CHANGE, LEDS, 32'h0000_00FF, 1);
		offer_led_cmd(lcfe_pkg::KIND_CHANGE, 5, 32'h0080_FF00, 3);
		offer_led_cmd(lcfe_pkg::KIND_TICK, 0, 32'h0000_0000, 0);
		offer_led_cmd(lcfe_pkg::KIND_TICK, 0, 32'h0000_0000, 0);
		// restart a fade half way
		offer_led_cmd(lcfe_pkg::KIND_CHANGE, 5, 32'h0000_0000, 2);
		offer_led_cmd(lcfe_pkg::KIND_CHANGE, 7, 32'h0000_0000, 4);
		offer_led_cmd(lcfe_pkg::KIND_TICK, 0, 32'h0000_0000, 0);
		offer_led_cmd(lcfe_pkg::KIND_CHANGE, 1, 32'hAA55_AA55, 1);
		offer_led_cmd(lcfe_pkg::KIND_TICK, 0, 32'h0000_0000, 0);
		offer_led_cmd(lcfe_pkg::KIND_TICK, 0, 32'h0000_0000, 0);
		offer_led_cmd(lcfe_pkg::KIND_TICK, 0, 32'h0000_0000, 0);
		offer_led_cmd(lcfe_pkg::KIND_TICK, 63, 32'hFFFF_FFFF, 32767);

		wait_idle();
		program_background(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		random_phase(PHASE_ITEMS);

		wait_idle();
		program_background($urandom(), 32'd3, 1'b0);
		random_phase(PHASE_ITEMS);

		wait_idle();
		program_background(32'h0000_0000, 32'h0000_0000, 1'b1);
		random_phase(PHASE_ITEMS);

		wait_idle();
		program_background($urandom(), ($urandom() & 32'hFFFF_8000) | $urandom_range(0, 8),
			1'b0);
		random_phase(PHASE_ITEMS);

		wait_idle();
		if (mismatch_count == 0 && pending_results == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
